// File: rtl/kepler_eccentric_anomaly_top_assert.svh
// Assertion macros for the Kepler eccentric anomaly solver.
// Included by the modules that check their own sequencing; no dependencies.
`ifndef KEPLER_ECCENTRIC_ANOMALY_TOP_ASSERT_SVH
`define KEPLER_ECCENTRIC_ANOMALY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KEA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KEA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define KEA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define KEA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/kea_pkg.sv
// Package for the Kepler eccentric anomaly solver: widths, Q30 constants,
// the CORDIC arctangent function. No dependencies.
package kea_pkg;
    localparam int FRACTION_BITS    = 28;
    localparam int MAX_NEWTON_STEPS = 16;
    localparam int CORDIC_STEPS     = 30;
    localparam int ANG_W   = 32;
    localparam int ECC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int STEPS_W = 5;
    localparam int CIDX_W  = 5;
    localparam int W       = 66;   // working width for angles and products
    localparam int DIV_W   = 64;   // divider magnitude width

    localparam logic [0:0] CFG_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_TOLERANCE = 1'b1;
    localparam logic [15:0] THRESHOLD_RESET = 16'd3277;
    localparam logic [15:0] TOLERANCE_RESET = 16'd4685;

    localparam logic signed [W-1:0] ONE_Q30     = 66'sd1073741824;
    localparam logic signed [W-1:0] PI_Q30      = 66'sd3373259426;
    localparam logic signed [W-1:0] HALF_PI_Q30 = 66'sd1686629713;
    localparam logic signed [W-1:0] TWO_PI_Q30  = 66'sd6746518852;
    localparam logic signed [W-1:0] GAIN_Q30    = 66'sd652032874;
    localparam logic signed [W-1:0] NUM_LIMIT   = 66'sd4294967296;
    localparam logic signed [W-1:0] S32_MAX     = 66'sd2147483647;
    localparam logic signed [W-1:0] S32_MIN     = -66'sd2147483648;

    typedef logic signed [W-1:0] word_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [63:0] acc;
        logic [63:0] term;
        acc = '0;
        if (i == 5'd0)
        begin
            return 32'd843314857;
        end
        for (int n = 0; n < 32; n++)
        begin
            if (int'(i) * (2 * n + 1) <= 62)
            begin
                term = (64'd1 << (62 - int'(i) * (2 * n + 1))) / 64'(2 * n + 1);
                acc = (n % 2 == 1) ? acc - term : acc + term;
            end
        end
        acc = (acc + (64'd1 << 31)) >> 32;
        return acc[31:0];
    endfunction
endpackage

// File: rtl/kea_stream_if.sv
// Valid/ready stream channel for the Kepler solver.
// Field width is set by the DATA_W parameter; no dependencies.
interface kea_stream_if #(parameter int DATA_W = 48);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/kepler_eccentric_anomaly_top.sv
// Channel | dir | payload
// in      | in  | data[31:0] mean_anomaly (Q3.28), data[47:32] eccentricity (Q0.16)
// out     | out | data[31:0] eccentric_anomaly, data[36:32] newton_steps,
//         |     | data[37] converged
// cfg     | in  | cfg_we, cfg_index, cfg_wdata
// Not iterated (eccentricity at or below the threshold): one 30-step CORDIC and the
// series. Each Newton step runs one CORDIC, a 64-step restoring divider and the setup
// and update states. A new item is taken only when the sequencer is back in idle.
// Iterated: the series, then Newton steps until the tolerance is met or the 16-step cap.
// Reset returns the sequencer to idle and the registers to their reset values.
// A result waits in the output register while out.ready is low; the solver takes
// the next item meanwhile and holds its own result until the register frees.
// Depends on kea_pkg, kea_stream_if and the assertion header.
`include "kepler_eccentric_anomaly_top_assert.svh"
module kepler_eccentric_anomaly_top (
    input  logic         clk,
    input  logic         rst_n,
    kea_stream_if.sink   in,
    kea_stream_if.source out,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);
    import kea_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_TRIG = 4'd1, S_CORD = 4'd2,
        S_EMUL = 4'd3, S_SER = 4'd4, S_NUM = 4'd5, S_DIV = 4'd6,
        S_UPD = 4'd7, S_OUT = 4'd8, S_FOLD = 4'd9, S_SER2 = 4'd10, S_DLD = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [15:0] thr_reg, tol_reg;
    word_t m_reg, est_reg, x_reg, y_reg, z_reg, es_reg, ec_reg, acc_reg;
    logic [15:0] e_reg;
    logic neg_reg, newton_reg, conv_reg;
    logic [CIDX_W-1:0] ci_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [DIV_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0] dcnt_reg;
    logic qneg_reg;
    logic out_valid_reg;
    logic [37:0] out_data_reg;

    word_t a_q30, qsum, t_red, dx, dy, num_c, nxt, diff;
    logic [DIV_W:0] rem_sh;
    logic [DIV_W-1:0] dividend;
    logic dividend_neg;
    logic tol_met, step_cap, out_free;
    logic [31:0] atan_tab [CORDIC_STEPS];

    // arctangent table, fixed at elaboration
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_atan
        localparam logic [31:0] ATAN_G = atan_q30(5'(g));
        assign atan_tab[g] = ATAN_G;
    end

    // shared CORDIC shifts
    assign dx = y_reg >>> ci_reg;
    assign dy = x_reg >>> ci_reg;
    assign a_q30 = est_reg <<< (30 - FRACTION_BITS);
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};

    // dividend: |N| * 2^30, loaded into the quotient shift word
    assign dividend_neg = num_c[W-1];
    assign dividend = DIV_W'((dividend_neg ? -num_c : num_c) <<< 30);

    assign tol_met = (acc_reg <= $signed({50'd0, tol_reg}));
    assign step_cap = (steps_reg == STEPS_W'(MAX_NEWTON_STEPS));
    assign out_free = !out_valid_reg || out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            tol_reg <= TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_THRESHOLD) thr_reg <= cfg_wdata;
            else tol_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        // angle range reduction: at most two 2*pi corrections for 32-bit inputs
        qsum = a_q30;
        if (qsum >= PI_Q30) qsum = qsum - TWO_PI_Q30;
        if (qsum >= PI_Q30) qsum = qsum - TWO_PI_Q30;
        if (qsum < -PI_Q30) qsum = qsum + TWO_PI_Q30;
        if (qsum < -PI_Q30) qsum = qsum + TWO_PI_Q30;
        t_red = qsum;
        num_c = acc_reg;
        if (num_c > NUM_LIMIT) num_c = NUM_LIMIT;
        if (num_c < -NUM_LIMIT) num_c = -NUM_LIMIT;
        nxt = est_reg - (qneg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg}));
        if (nxt > S32_MAX) nxt = S32_MAX;
        if (nxt < S32_MIN) nxt = S32_MIN;
        diff = est_reg - nxt;
        if (diff < 0) diff = -diff;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in.valid && in.ready) state_next = S_FOLD;
            S_FOLD: state_next = S_CORD;
            S_TRIG:
            begin
                if ((newton_reg && tol_met) || step_cap) state_next = S_OUT;
                else state_next = S_FOLD;
            end
            S_CORD: if (ci_reg == CIDX_W'(CORDIC_STEPS - 1)) state_next = S_EMUL;
            S_EMUL: state_next = newton_reg ? S_NUM : S_SER;
            S_SER:  state_next = S_SER2;
            S_SER2: state_next = (e_reg > thr_reg) ? S_TRIG : S_OUT;
            S_NUM:  state_next = S_DLD;
            S_DLD:  state_next = S_DIV;
            S_DIV:  if (dcnt_reg == 6'd63) state_next = S_UPD;
            S_UPD:  state_next = S_TRIG;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            newton_reg <= 1'b0;
            conv_reg <= 1'b0;
            neg_reg <= 1'b0;
            qneg_reg <= 1'b0;
            m_reg <= '0;
            est_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            es_reg <= '0;
            ec_reg <= '0;
            acc_reg <= '0;
            e_reg <= '0;
            ci_reg <= '0;
            steps_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            dvs_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {conv_reg, steps_reg, est_reg[31:0]};
            end
            else if (out.valid && out.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in.valid && in.ready)
                    begin
                        m_reg <= W'($signed(in.data[31:0]));
                        est_reg <= W'($signed(in.data[31:0]));
                        e_reg <= in.data[47:32];
                        newton_reg <= 1'b0;
                        steps_reg <= '0;
                        conv_reg <= 1'b1;
                    end
                end
                S_TRIG:
                begin
                    // enter the Newton loop or end it
                    if (newton_reg && tol_met)
                        conv_reg <= 1'b1;
                    else if (step_cap)
                        conv_reg <= 1'b0;
                    else
                    begin
                        newton_reg <= 1'b1;
                        conv_reg <= 1'b0;
                    end
                end
                S_FOLD:
                begin
                    x_reg <= GAIN_Q30;
                    y_reg <= '0;
                    ci_reg <= '0;
                    if (t_red > HALF_PI_Q30)
                    begin
                        z_reg <= t_red - PI_Q30; neg_reg <= 1'b1;
                    end
                    else if (t_red < -HALF_PI_Q30)
                    begin
                        z_reg <= t_red + PI_Q30; neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg <= t_red; neg_reg <= 1'b0;
                    end
                end
                S_CORD:
                begin
                    ci_reg <= ci_reg + 1'b1;
                    if (!z_reg[W-1])
                    begin
                        x_reg <= x_reg - dx; y_reg <= y_reg + dy;
                        z_reg <= z_reg - W'(atan_tab[ci_reg]);
                    end
                    else
                    begin
                        x_reg <= x_reg + dx; y_reg <= y_reg - dy;
                        z_reg <= z_reg + W'(atan_tab[ci_reg]);
                    end
                end
                S_EMUL:
                begin
                    word_t c, s;
                    logic signed [47:0] ps, pc;
                    c = neg_reg ? -x_reg : x_reg;
                    s = neg_reg ? -y_reg : y_reg;
                    if (c > ONE_Q30) c = ONE_Q30;
                    if (c < -ONE_Q30) c = -ONE_Q30;
                    if (s > ONE_Q30) s = ONE_Q30;
                    if (s < -ONE_Q30) s = -ONE_Q30;
                    ps = $signed(s[31:0]) * $signed({1'b0, e_reg});
                    pc = $signed(c[31:0]) * $signed({1'b0, e_reg});
                    es_reg <= W'(ps >>> 16);
                    ec_reg <= W'(pc >>> 16);
                end
                S_SER:
                begin
                    word_t ecp;
                    logic signed [63:0] pser;
                    ecp = ONE_Q30 + ec_reg;
                    pser = $signed(es_reg[31:0]) * $signed(ecp[32:0]);
                    acc_reg <= W'(pser >>> (60 - FRACTION_BITS));
                end
                S_SER2:
                begin
                    word_t t;
                    t = m_reg + acc_reg;
                    if (t > S32_MAX) t = S32_MAX;
                    if (t < S32_MIN) t = S32_MIN;
                    est_reg <= t;
                end
                S_NUM:
                begin
                    acc_reg <= est_reg - (es_reg >>> (30 - FRACTION_BITS)) - m_reg;
                    dvs_reg <= DIV_W'(ONE_Q30 - ec_reg);
                end
                S_DLD:
                begin
                    // load the clamped numerator magnitude and its sign
                    quo_reg <= dividend;
                    qneg_reg <= dividend_neg;
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (rem_sh >= {1'b0, dvs_reg})
                    begin
                        rem_reg <= DIV_W'(rem_sh - {1'b0, dvs_reg});
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[DIV_W-1:0];
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                end
                S_UPD:
                begin
                    est_reg <= nxt;
                    steps_reg <= steps_reg + 1'b1;
                    acc_reg <= diff;
                end
                default: ;
            endcase
        end
    end

    assign in.ready = (state_reg == S_IDLE);
    assign out.valid = out_valid_reg;
    assign out.data = {10'd0, out_data_reg};

    `KEA_ASSERT_NEXT(a_in_starts, clk, rst_n, in.valid && in.ready, state_reg == S_FOLD,
        "accepted item did not start the solver")
    `KEA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_reg != S_IDLE) |-> !in.ready,
        "ready while busy")
    `KEA_ASSERT_IMPL(a_steps_cap, clk, rst_n,
        (steps_reg <= STEPS_W'(MAX_NEWTON_STEPS)), "step count over the cap")
    `KEA_ASSERT_NEXT(a_out_hold, clk, rst_n, out.valid && !out.ready,
        out.valid && $stable(out.data), "waiting result changed")
endmodule
